/* hw/rtl/ialu_pkg.sv */
// ----------------------------------------------------------------------------
// ialu_pkg
// Shared types, codes and the divider step for the integer ALU.
// ----------------------------------------------------------------------------
package ialu_pkg;

  localparam int unsigned DataWidth = 32;
  localparam int unsigned OpWidth   = 5;
  localparam int unsigned StWidth   = 2;
  localparam int unsigned DivSteps  = DataWidth;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD  = 5'd0,
    OP_SUB  = 5'd1,
    OP_MUL  = 5'd2,
    OP_SDIV = 5'd3,
    OP_SREM = 5'd4,
    OP_OR   = 5'd5,
    OP_XOR  = 5'd6,
    OP_AND  = 5'd7,
    OP_ASR  = 5'd8,
    OP_SHL  = 5'd9,
    OP_LSR  = 5'd10,
    OP_EQ   = 5'd11,
    OP_NE   = 5'd12,
    OP_GT   = 5'd13,
    OP_GE   = 5'd14,
    OP_LT   = 5'd15,
    OP_LE   = 5'd16
  } op_t;

  localparam logic [StWidth-1:0] ST_OK    = 2'd0;
  localparam logic [StWidth-1:0] ST_DIV0  = 2'd1;
  localparam logic [StWidth-1:0] ST_UNSUP = 2'd2;

  // Payload of one pipeline stage.
  typedef struct packed {
    logic [DataWidth-1:0] r;      // result of the non-divide ops
    logic [StWidth-1:0]   st;
    logic                 is_div; // sdiv or srem
    logic                 is_rem;
    logic                 neg_q;
    logic                 neg_r;
    logic [DataWidth-1:0] rem;    // partial remainder
    logic [DataWidth-1:0] quo;    // dividend shifting out, quotient shifting in
    logic [DataWidth-1:0] mb;     // divisor magnitude
  } pipe_t;

  // One restoring division step: one quotient bit.
  function automatic pipe_t div_step(input pipe_t p);
    pipe_t            o;
    logic [DataWidth:0] trial;
    o     = p;
    trial = {1'b0, p.rem[DataWidth-2:0], p.quo[DataWidth-1]} - {1'b0, p.mb};
    if (!trial[DataWidth]) begin
      o.rem = trial[DataWidth-1:0];
      o.quo = {p.quo[DataWidth-2:0], 1'b1};
    end else begin
      o.rem = {p.rem[DataWidth-2:0], p.quo[DataWidth-1]};
      o.quo = {p.quo[DataWidth-2:0], 1'b0};
    end
    return o;
  endfunction

endpackage

/* hw/rtl/ialu_if.sv */
// ----------------------------------------------------------------------------
// ialu request and response channels
// Valid/ready streams carrying operation words and result words.
// ----------------------------------------------------------------------------
interface ialu_req_if;
  logic                                      valid;
  logic                                      ready;
  logic [ialu_pkg::OpWidth-1:0]              operation;
  logic signed [ialu_pkg::DataWidth-1:0]     lhs_value;
  logic signed [ialu_pkg::DataWidth-1:0]     rhs_value;
  modport source (output valid, operation, lhs_value, rhs_value, input ready);
  modport sink   (input valid, operation, lhs_value, rhs_value, output ready);
endinterface

interface ialu_rsp_if;
  logic                                      valid;
  logic                                      ready;
  logic signed [ialu_pkg::DataWidth-1:0]     result_value;
  logic [ialu_pkg::StWidth-1:0]              status;
  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

/* hw/rtl/integer_alu_with_compare_core.sv */
// ----------------------------------------------------------------------------
// integer_alu_with_compare_core
// Pipelined 32-bit signed ALU: arithmetic, logic, shifts, compares, div/rem.
// ----------------------------------------------------------------------------
//  channel  dir  words                                  handshake
//  req      in   operation, lhs_value, rhs_value        valid/ready
//  rsp      out  result_value, status                   valid/ready
//
//  One word enters per cycle while rsp is not stalled; each result passes the
//  input register, operand/multiply stage, 32 divider stages, output register.
//  The depth is set by the bit-serial divider, one quotient bit a stage.
//  rst clears all valid bits; payload registers are not reset.
//  A stalled rsp freezes the whole pipe; req.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module integer_alu_with_compare_core (
  input  logic      clk,
  input  logic      rst,
  ialu_req_if.sink  req,
  ialu_rsp_if.source rsp
);

  localparam int unsigned W = ialu_pkg::DataWidth;
  localparam int unsigned N = ialu_pkg::DivSteps;

  logic adv;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv;

  // input register
  logic                            s0_vld;
  logic [ialu_pkg::OpWidth-1:0]    s0_op;
  logic [W-1:0]                    s0_a;
  logic [W-1:0]                    s0_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_vld <= 1'b0;
    end else if (adv) begin
      s0_vld <= req.valid;
    end
    if (adv) begin
      s0_op <= req.operation;
      s0_a  <= req.lhs_value;
      s0_b  <= req.rhs_value;
    end
  end

  // operand stage: non-divide ops, multiply, divider setup
  ialu_pkg::pipe_t s1_next;
  logic [4:0]      sh;
  logic            lt_ab;
  logic            lt_ba;

  always_comb begin
    sh    = s0_b[4:0];
    lt_ab = $signed(s0_a) < $signed(s0_b);
    lt_ba = $signed(s0_b) < $signed(s0_a);
    s1_next        = '0;
    s1_next.st     = ialu_pkg::ST_OK;
    s1_next.neg_q  = s0_a[W-1] ^ s0_b[W-1];
    s1_next.neg_r  = s0_a[W-1];
    s1_next.quo    = s0_a[W-1] ? (W'(0) - s0_a) : s0_a;
    s1_next.mb     = s0_b[W-1] ? (W'(0) - s0_b) : s0_b;
    case (s0_op)
      ialu_pkg::OP_ADD:  s1_next.r = s0_a + s0_b;
      ialu_pkg::OP_SUB:  s1_next.r = s0_a - s0_b;
      ialu_pkg::OP_MUL:  s1_next.r = s0_a * s0_b;
      ialu_pkg::OP_SDIV, ialu_pkg::OP_SREM: begin
        s1_next.is_div = 1'b1;
        s1_next.is_rem = (s0_op == ialu_pkg::OP_SREM);
        if (s0_b == '0) s1_next.st = ialu_pkg::ST_DIV0;
      end
      ialu_pkg::OP_OR:   s1_next.r = s0_a | s0_b;
      ialu_pkg::OP_XOR:  s1_next.r = s0_a ^ s0_b;
      ialu_pkg::OP_AND:  s1_next.r = s0_a & s0_b;
      ialu_pkg::OP_ASR:  s1_next.r = $unsigned($signed(s0_a) >>> sh);
      ialu_pkg::OP_SHL:  s1_next.r = s0_a << sh;
      ialu_pkg::OP_LSR:  s1_next.r = s0_a >> sh;
      ialu_pkg::OP_EQ:   s1_next.r = W'(s0_a == s0_b);
      ialu_pkg::OP_NE:   s1_next.r = W'(s0_a != s0_b);
      ialu_pkg::OP_GT:   s1_next.r = W'(lt_ba);
      ialu_pkg::OP_GE:   s1_next.r = W'(!lt_ab);
      ialu_pkg::OP_LT:   s1_next.r = W'(lt_ab);
      ialu_pkg::OP_LE:   s1_next.r = W'(!lt_ba);
      default:           s1_next.st = ialu_pkg::ST_UNSUP;
    endcase
  end

  logic            s1_vld;
  ialu_pkg::pipe_t s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= s0_vld;
    end
    if (adv) s1 <= s1_next;
  end

  // divider stages
  logic            dv_vld [N];
  ialu_pkg::pipe_t dv     [N];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < N; i++) dv_vld[i] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= s1_vld;
      for (int i = 1; i < N; i++) dv_vld[i] <= dv_vld[i-1];
    end
    if (adv) begin
      dv[0] <= ialu_pkg::div_step(s1);
      for (int i = 1; i < N; i++) dv[i] <= ialu_pkg::div_step(dv[i-1]);
    end
  end

  // sign fix and select
  ialu_pkg::pipe_t      fin;
  logic [W-1:0]         res_next;

  always_comb begin
    fin      = dv[N-1];
    res_next = fin.r;
    if (fin.st != ialu_pkg::ST_OK) begin
      res_next = '0;
    end else if (fin.is_div) begin
      if (fin.is_rem) res_next = fin.neg_r ? (W'(0) - fin.rem) : fin.rem;
      else            res_next = fin.neg_q ? (W'(0) - fin.quo) : fin.quo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= dv_vld[N-1];
    end
    if (adv) begin
      rsp.result_value <= res_next;
      rsp.status       <= fin.st;
    end
  end

  // checks
  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ialu_pkg::ST_DIV0 |-> rsp.result_value == '0)
    else $error("divide by zero with nonzero result");

  a_unsup_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ialu_pkg::ST_UNSUP |-> rsp.result_value == '0)
    else $error("unsupported code with nonzero result");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid && !s0_vld && !s1_vld)
    else $error("pipeline valid after reset");

  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(dv_vld[N-1]) && $stable(s1_vld))
    else $error("pipeline moved during stall");

endmodule
